// ===== rtl/core/fes_pkg.sv =====
// shared types and constants for the escape-time evaluator
`default_nettype none
package fes_pkg;

  // fixed-point format of z and c
  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 28;
  localparam int PROD_W      = 2 * DATA_W;

  // counts and configuration widths
  localparam int COUNT_WIDTH = 10;
  localparam int LIMIT_W     = 10;
  localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FORMULA_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  // escape threshold: 4 at scale 2*FRAC_BITS
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit ESC_IN_RANGE = (ESC_SHIFT < PROD_W);
  localparam logic [PROD_W-1:0] ESC_LIMIT =
    ESC_IN_RANGE ? (PROD_W'(1) << ESC_SHIFT) : '0;

  // saturation bounds of the z register
  localparam logic signed [PROD_W-1:0] Z_MAX = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] Z_MIN = -(PROD_W'(64'sd1 <<< (DATA_W - 1)));

  typedef logic signed [DATA_W-1:0] z_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [COUNT_WIDTH-1:0]   count_t;
  typedef logic [LIMIT_W-1:0]       limit_t;

  // products of one iteration, handed to the update logic
  typedef struct packed {
    prod_t rr;
    prod_t ii;
    prod_t ri;
  } prods_t;

endpackage
`default_nettype wire

// ===== rtl/core/fes_in_if.sv =====
// input channel: starting point z and constant c
`default_nettype none
interface fes_in_if import fes_pkg::*; ;
  logic valid;
  logic ready;
  z_t   start_real;
  z_t   start_imag;
  z_t   const_real;
  z_t   const_imag;

  modport source (output valid, start_real, start_imag, const_real, const_imag,
                  input ready);
  modport sink   (input valid, start_real, start_imag, const_real, const_imag,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fes_out_if.sv =====
// result channel: escape count and bounded flag
`default_nettype none
interface fes_out_if import fes_pkg::*; ;
  logic   valid;
  logic   ready;
  count_t escape_count;
  logic   never_escaped;

  modport source (output valid, escape_count, never_escaped, input ready);
  modport sink   (input valid, escape_count, never_escaped, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fractal_escape_time.sv =====
// escape-time evaluator: sequencer around one shared multiplier
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------------
//   in_ch    | in  | valid / ready        | start_real, start_imag, const_real, const_imag
//   out_ch   | out | valid / ready        | escape_count, never_escaped
//   cfg_*    | in  | cfg_wr_en            | cfg_index, cfg_wr_data
//
// one multiplier forms re*re, im*im and re*im in turn, so each iteration
// steps through S_RR, S_II, S_RI and, unless the point exits, S_UPD. reset
// is synchronous, active low, and restores formula_mode = 0 and
// iteration_limit = 100. a result waits in the output register while the
// sink stalls; the next request is taken meanwhile.
`default_nettype none
module fractal_escape_time import fes_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fes_in_if.sink                     in_ch,
  fes_out_if.source                  out_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_RI   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       mode_r;
  limit_t     limit_r;
  z_t         re_r, im_r, cr_r, ci_r;
  prod_t      rr_r, ii_r;
  count_t     count_r;
  count_t     res_count_r;
  logic       res_flag_r;
  logic       out_valid_r;
  count_t     out_count_r;
  logic       out_flag_r;

  z_t          op_a, op_b;
  prod_t       prod_r;
  prods_t      prods;
  z_t          next_real, next_imag;
  logic [PROD_W-1:0] mag;
  logic        escaped;
  logic        at_limit;
  logic        in_take;
  logic        out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FORMULA_MODE: mode_r  <= cfg_wr_data[0];
        CFG_ITER_LIMIT:   limit_r <= cfg_wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_RR: begin
        op_a = re_r;
        op_b = re_r;
      end
      S_II: begin
        op_a = im_r;
        op_b = im_r;
      end
      default: begin
        op_a = re_r;
        op_b = im_r;
      end
    endcase
  end

  fes_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // escape test in S_RI, where prod_r holds im*im
  assign mag      = rr_r + prod_r;
  assign escaped  = ESC_IN_RANGE && (mag > ESC_LIMIT);
  assign at_limit = CMP_W'(count_r) >= CMP_W'(limit_r);

  assign prods = '{rr: rr_r, ii: ii_r, ri: prod_r};

  fes_update u_update (
    .formula_mode (mode_r),
    .prods        (prods),
    .c_real       (cr_r),
    .c_imag       (ci_r),
    .next_real    (next_real),
    .next_imag    (next_imag)
  );

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_take) state_nxt = S_RR;
      S_RR:   state_nxt = S_II;
      S_II:   state_nxt = S_RI;
      S_RI:   state_nxt = (escaped || at_limit) ? S_WAIT : S_UPD;
      S_UPD:  state_nxt = S_RR;
      S_WAIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // iteration datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          re_r    <= in_ch.start_real;
          im_r    <= in_ch.start_imag;
          cr_r    <= in_ch.const_real;
          ci_r    <= in_ch.const_imag;
          count_r <= '0;
        end
      end
      S_II: rr_r <= prod_r;
      S_RI: begin
        ii_r        <= prod_r;
        res_flag_r  <= !escaped;
        res_count_r <= escaped ? count_r : '0;
      end
      S_UPD: begin
        re_r    <= next_real;
        im_r    <= next_imag;
        count_r <= count_r + COUNT_WIDTH'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_WAIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && out_free) begin
      out_count_r <= res_count_r;
      out_flag_r  <= res_flag_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.escape_count  = out_count_r;
  assign out_ch.never_escaped = out_flag_r;

  // iteration count stays within the limit while a point is in flight
  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (CMP_W'(count_r) < CMP_W'(limit_r)))
    else $error("iteration count passed the limit");

  // a bounded point reports a zero count
  a_bounded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.never_escaped) |-> (out_ch.escape_count == '0))
    else $error("bounded result with nonzero count");

  // an accepted request starts with the first square
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_RR && count_r == '0))
    else $error("request did not start an evaluation");

  // the escape test is only left for an update when the point has not escaped
  a_update_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ($past(state_r) == S_RI && !$past(escaped)))
    else $error("update entered after an exit condition");

endmodule
`default_nettype wire

// ===== rtl/core/fes_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none
module fes_mul import fes_pkg::*; (
  input  wire logic clk,
  input  wire z_t   op_a,
  input  wire z_t   op_b,
  output prod_t     prod_r
);

  // one full-width product per cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule
`default_nettype wire

// ===== rtl/core/fes_update.sv =====
// next z from the three products: floor shift, add c (abs form: subtract |c_real|), saturate
`default_nettype none
module fes_update import fes_pkg::*; (
  input  wire logic   formula_mode,
  input  wire prods_t prods,
  input  wire z_t     c_real,
  input  wire z_t     c_imag,
  output z_t          next_real,
  output z_t          next_imag
);

  prod_t diff;
  prod_t diff_abs;
  prod_t cr_ext;
  prod_t cr_abs;
  prod_t ci_ext;
  prod_t nre;
  prod_t nim;

  function automatic z_t sat_z(input prod_t v);
    if (v > Z_MAX) begin
      sat_z = z_t'(Z_MAX);
    end else if (v < Z_MIN) begin
      sat_z = z_t'(Z_MIN);
    end else begin
      sat_z = v[DATA_W-1:0];
    end
  endfunction

  // real part: plain or absolute-value form
  always_comb begin
    diff     = prods.rr - prods.ii;
    diff_abs = diff[PROD_W-1] ? -diff : diff;
    cr_ext   = PROD_W'(c_real);
    cr_abs   = cr_ext[PROD_W-1] ? -cr_ext : cr_ext;
    if (formula_mode) begin
      nre = (diff_abs >>> FRAC_BITS) - cr_abs;
    end else begin
      nre = (diff >>> FRAC_BITS) + cr_ext;
    end
  end

  // imaginary part: 2*re*im folded into the shift
  always_comb begin
    ci_ext = PROD_W'(c_imag);
    nim    = (prods.ri >>> (FRAC_BITS - 1)) + ci_ext;
  end

  assign next_real = sat_z(nre);
  assign next_imag = sat_z(nim);

endmodule
`default_nettype wire

// ===== tb/tb_fractal_escape_time.sv =====
// testbench for the escape-time evaluator: predicts counts and checks every result
`timescale 1ns / 100ps
module tb_fractal_escape_time;
  import fes_pkg::*;

  // handy fixed-point values
  localparam int ONE = 1 << FRAC_BITS;
  localparam int TWO = 2 * ONE;
  localparam z_t MAXV = 32'sh7FFF_FFFF;
  localparam z_t MINV = 32'sh8000_0000;
  localparam int SQ_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit FOUR_FITS = (SQ_SHIFT < 64);
  localparam longint unsigned FOUR_SCALED = 64'd1 << (SQ_SHIFT % 64);
  localparam int MAX_CYCLES = 2_500_000;

  typedef struct packed {
    z_t start_real;
    z_t start_imag;
    z_t const_real;
    z_t const_imag;
  } point_t;

  typedef struct packed {
    count_t escape_count;
    logic   never_escaped;
  } escape_result_t;

  typedef struct {
    point_t         pt;
    escape_result_t res;
  } pending_t;

  // escape-time predictor plus queue of results still owed by the block
  class escape_scoreboard;
    bit       mode;
    limit_t   limit;
    pending_t owed_q[$];
    int       errors;
    int       checked;
    int       escaped_cnt;
    int       bounded_cnt;

    function new();
      mode  = 1'b0;
      limit = LIMIT_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FORMULA_MODE: mode = data[0];
        CFG_ITER_LIMIT:   limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit exceeds_four(longint re, longint im);
      longint unsigned mag;
      mag = longint'(re * re) + longint'(im * im);
      if (!FOUR_FITS) return 1'b0;
      return mag > FOUR_SCALED;
    endfunction

    function longint clamp_z(longint v);
      if (v > longint'(Z_MAX)) return longint'(Z_MAX);
      if (v < longint'(Z_MIN)) return longint'(Z_MIN);
      return v;
    endfunction

    function escape_result_t predict_escape(point_t p);
      longint re, im, cr, ci, diff, nre, nim;
      int unsigned n;
      bit gone;
      escape_result_t r;
      re = p.start_real;
      im = p.start_imag;
      cr = p.const_real;
      ci = p.const_imag;
      n = 0;
      gone = exceeds_four(re, im);
      while (!gone && n < limit) begin
        diff = re * re - im * im;
        if (mode) begin
          // abs variant: fold both the difference and c_real
          nre = (((diff < 0) ? -diff : diff) >>> FRAC_BITS) - ((cr < 0) ? -cr : cr);
        end else begin
          nre = (diff >>> FRAC_BITS) + cr;
        end
        nim = ((re * im) >>> (FRAC_BITS - 1)) + ci;
        re = clamp_z(nre);
        im = clamp_z(nim);
        n++;
        gone = exceeds_four(re, im);
      end
      r.escape_count  = gone ? count_t'(n) : '0;
      r.never_escaped = !gone;
      return r;
    endfunction

    function void note_point(point_t p);
      pending_t e;
      e.pt  = p;
      e.res = predict_escape(p);
      owed_q.push_back(e);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(count_t cnt, logic flag);
      pending_t e;
      if (owed_q.size() == 0) begin
        flag_error($sformatf("unexpected result: count %0d never_escaped %b", cnt, flag));
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (e.res.never_escaped) bounded_cnt++;
      else escaped_cnt++;
      if (cnt !== e.res.escape_count || flag !== e.res.never_escaped) begin
        flag_error($sformatf(
          "mismatch z=(%h,%h) c=(%h,%h) mode %0d limit %0d: exp count %0d flag %b, got %0d %b",
          e.pt.start_real, e.pt.start_imag, e.pt.const_real, e.pt.const_imag, mode, limit,
          e.res.escape_count, e.res.never_escaped, cnt, flag));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  bit   quiet;
  int   cycles = 0;
  int   settings;
  escape_scoreboard board;

  fes_in_if  in_ch ();
  fes_out_if out_ch ();

  fractal_escape_time dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, board.owed_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.escape_count, out_ch.never_escaped);
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result sink with random back-pressure
  initial begin
    int hold;
    int s;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_ch.ready) begin
        s = idle_len();
        if (s > 0) begin
          out_ch.ready = 1'b0;
          hold = s - 1;
        end else begin
          hold = $urandom_range(0, 7);
        end
      end else begin
        out_ch.ready = 1'b1;
        hold = $urandom_range(0, 15);
      end
    end
  end

  function automatic point_t make_point(z_t sr, z_t si, z_t cr, z_t ci);
    point_t p;
    p.start_real = sr;
    p.start_imag = si;
    p.const_real = cr;
    p.const_imag = ci;
    return p;
  endfunction

  function automatic z_t rand_between(int lo, int hi);
    return z_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic z_t corner_value();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return TWO;
      4: return -TWO;
      default: return z_t'($urandom());
    endcase
  endfunction

  // mix of map-plane points, julia points, small noise, full-range noise and corners
  function automatic point_t random_point(z_t jre, z_t jim);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      return make_point('0, '0, rand_between(-(TWO + ONE / 4), 3 * ONE / 4),
                        rand_between(-(3 * ONE / 2), 3 * ONE / 2));
    if (pick < 65)
      return make_point(rand_between(-TWO, TWO), rand_between(-TWO, TWO),
                        jre + rand_between(-ONE / 64, ONE / 64),
                        jim + rand_between(-ONE / 64, ONE / 64));
    if (pick < 78)
      return make_point(rand_between(-TWO, TWO), rand_between(-TWO, TWO),
                        rand_between(-TWO, TWO), rand_between(-TWO, TWO));
    if (pick < 92)
      return make_point(z_t'($urandom()), z_t'($urandom()), z_t'($urandom()),
                        z_t'($urandom()));
    return make_point(corner_value(), corner_value(), corner_value(), corner_value());
  endfunction

  // one request on the input channel; starts and ends at a falling edge
  task automatic send_point(point_t p);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.start_real = p.start_real;
    in_ch.start_imag = p.start_imag;
    in_ch.const_real = p.const_real;
    in_ch.const_imag = p.const_imag;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_point(p);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.write_reg(idx, data);
  endtask

  // let the block go idle, then load a new setting; upper mode bits are junk
  task automatic set_phase(bit mode_bit, int lim);
    in_ch.valid = 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
    write_cfg(CFG_FORMULA_MODE, (CFG_DATA_W'($urandom_range(0, 511)) << 1) | mode_bit);
    write_cfg(CFG_ITER_LIMIT, CFG_DATA_W'(lim));
    quiet = ($urandom_range(0, 3) == 0);
    settings++;
  endtask

  // random phases: mode, limit, request count
  int plan_mode  [10] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
  int plan_limit [10] = '{1023, 1023, 100, 100, 30, 7, 255, 1, 500, 0};
  int plan_count [10] = '{8, 6, 300, 200, 200, 150, 80, 100, 20, 30};

  initial begin
    z_t jre;
    z_t jim;
    board = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.start_real = '0;
    in_ch.start_imag = '0;
    in_ch.const_real = '0;
    in_ch.const_imag = '0;
    quiet = 1'b0;
    settings = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting: quadratic map, limit 100
    send_point(make_point('0, '0, '0, '0));
    send_point(make_point(MAXV, MAXV, MAXV, MAXV));
    send_point(make_point(MINV, MINV, MINV, MINV));
    send_point(make_point(TWO, '0, '0, '0));
    send_point(make_point('0, '0, -TWO, '0));
    send_point(make_point('0, '0, ONE / 4, '0));
    send_point(make_point('0, '0, ONE, '0));
    send_point(make_point(TWO, '0, MAXV, MINV));
    send_point(make_point('0, -TWO, '0, '0));
    send_point(make_point('0, '0, -(3 * ONE / 4), ONE / 10));
    send_point(make_point(ONE, ONE, '0, '0));

    // abs variant, single iteration: negative difference, negative c_real
    in_ch.valid = 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
    write_cfg(CFG_FORMULA_MODE, 10'h3FF);
    write_cfg(CFG_ITER_LIMIT, 10'd1);
    settings++;
    send_point(make_point('0, ONE, '0, '0));
    send_point(make_point(ONE, '0, -ONE, ONE / 2));
    send_point(make_point(TWO, '0, -TWO, MINV));

    // abs variant at the largest limit
    set_phase(1'b1, 1023);
    send_point(make_point('0, '0, '0, '0));
    send_point(make_point('0, '0, -(7 * ONE / 4), -(ONE / 32)));

    // zero limit: only the check before the first iteration counts
    set_phase(1'b0, 0);
    send_point(make_point('0, '0, '0, '0));
    send_point(make_point(MAXV, '0, '0, '0));
    send_point(make_point(TWO, '0, MAXV, MAXV));

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      set_phase(plan_mode[ph][0], plan_limit[ph]);
      jre = rand_between(-(3 * ONE / 2), ONE / 2);
      jim = rand_between(-ONE, ONE);
      repeat (plan_count[ph]) send_point(random_point(jre, jim));
    end

    // drain, then give a stray result time to show up
    in_ch.valid = 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (4 * (int'(board.limit) + 2) + 20) @(posedge clk);
    if (board.owed_q.size() != 0)
      board.flag_error($sformatf("%0d results never arrived", board.owed_q.size()));

    $display("checked %0d points over %0d register settings: %0d escaped, %0d bounded",
             board.checked, settings, board.escaped_cnt, board.bounded_cnt);
    $display("%0d errors in %0d cycles", board.errors, cycles);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
